[rtl/lgsi_pkg.sv]
// shared types and constants of the log-grid spectrum interpolator
package lgsi_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] OUTC_REJECT = 2'd0;
  localparam logic [1:0] OUTC_EXACT  = 2'd1;
  localparam logic [1:0] OUTC_INTERP = 2'd2;

  localparam logic REG_REST_MASS    = 1'b0;
  localparam logic REG_ENTRIES_USED = 1'b1;

  localparam logic [16:0] RST_REST_MASS    = 17'd100;
  localparam logic [8:0]  RST_ENTRIES_USED = 9'd179;

  localparam logic [31:0] LOG10_2_Q32  = 32'd1292913986;
  localparam logic [31:0] INV_LN10_Q32 = 32'd1865280597;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [5:0]  shamt;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        ovf;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

[rtl/lgsi_stream_if.sv]
// valid/ready channels for input items and result items
interface lgsi_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         entry_index;
  logic signed [31:0] grid_log10x;
  logic [63:0]        entry_value;
  logic [63:0]        energy_gev;

  modport source (output valid, operation, entry_index, grid_log10x, entry_value, energy_gev,
                  input ready);
  modport sink (input valid, operation, entry_index, grid_log10x, entry_value, energy_gev,
                output ready);
endinterface

interface lgsi_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] particles_per_energy;
  logic        saturated;
  logic [1:0]  outcome;

  modport source (output valid, particles_per_energy, saturated, outcome, input ready);
  modport sink (input valid, particles_per_energy, saturated, outcome, output ready);
endinterface

[rtl/log_grid_spectrum_interpolator_unit.sv]
// a query on the full path runs through the bit-serial divider (three passes, k = 36, 32, 16),
// the normalize shift, the squaring loop and the table search; a query rejected at the input
// goes straight from the idle state to the output state and then into the result register
// writes are taken while idle; one item at a time, the next is taken once the query finishes
// reset clears the sequencer and the result valid flag, loads rest mass 100 and 179 entries
// table contents are undefined until written
module log_grid_spectrum_interpolator_unit
  import lgsi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lgsi_item_if.sink     item_i,
  lgsi_result_if.source result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned IDXW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW   = IDXW + 1;
  localparam logic [31:0] DEPTH32   = 32'(TABLE_DEPTH);
  localparam logic [63:0] MAG_LIMIT = 64'h0000_0000_8000_0000;

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_DIV      = 14'h0002,
    S_NORM     = 14'h0004,
    S_SQ_MUL   = 14'h0008,
    S_SQ_UPD   = 14'h0010,
    S_MQ_HI    = 14'h0020,
    S_MQ_LO    = 14'h0040,
    S_MQ_SUM   = 14'h0080,
    S_SRCH     = 14'h0100,
    S_SRCH_CMP = 14'h0200,
    S_CHK1     = 14'h0400,
    S_CHK0     = 14'h0800,
    S_VAL      = 14'h1000,
    S_OUT      = 14'h2000
  } state_e;

  typedef enum logic [1:0] {
    DP_X    = 2'd0,
    DP_FRAC = 2'd1,
    DP_RES  = 2'd2
  } div_ph_e;

  typedef enum logic [1:0] {
    MP_LOG    = 2'd0,
    MP_INTERP = 2'd1,
    MP_WEIGHT = 2'd2
  } mul_ph_e;

  state_e  state_q, state_d;
  div_ph_e dph_q, dph_d;
  mul_ph_e mph_q, mph_d;

  logic [16:0] mass_q, mass_d;
  logic [8:0]  ent_q, ent_d;

  logic [63:0]        e_q, e_d;
  logic [63:0]        norm_q, norm_d;
  logic [6:0]         lz_q, lz_d;
  logic [31:0]        mq_q, mq_d;
  logic [31:0]        frac_q, frac_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [63:0]        mqa_q, mqa_d;
  logic [31:0]        mqc_q, mqc_d;
  logic [63:0]        ph_q, ph_d;
  logic signed [31:0] lg_q, lg_d;
  logic [NW-1:0]      lo_q, lo_d;
  logic [NW-1:0]      up_q, up_d;
  logic [NW-1:0]      mid_q, mid_d;
  logic signed [31:0] g1_q, g1_d;
  logic [63:0]        v1_q, v1_d;
  logic [63:0]        v0_q, v0_d;
  logic [63:0]        val_q, val_d;
  logic [1:0]         outc_q, outc_d;
  logic [63:0]        fin_res_q, fin_res_d;
  logic               fin_sat_q, fin_sat_d;
  logic [1:0]         fin_outc_q, fin_outc_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_res_q, out_res_d;
  logic        out_sat_q, out_sat_d;
  logic [1:0]  out_outc_q, out_outc_d;

  logic signed [31:0] grid_mem [TABLE_DEPTH];
  logic [63:0]        val_mem [TABLE_DEPTH];
  logic signed [31:0] rd_grid_q;
  logic [63:0]        rd_val_q;
  logic [IDXW-1:0]    rd_addr;
  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic          in_fire;
  logic          cfg_wr;
  logic [NW-1:0] n_cnt;
  logic [NW:0]   mid_sum;
  logic [NW-1:0] lo_m1;
  logic [63:0]   sq;
  logic [31:0]   frac_new;
  logic [63:0]   acc;
  logic [63:0]   mag28;
  logic [32:0]   num33, den33;

  lgsi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lgsi_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_fire = item_i.valid & item_i.ready;
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_REST_MASS:    prdata = {15'd0, mass_q};
      REG_ENTRIES_USED: prdata = {23'd0, ent_q};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    mass_d = mass_q;
    ent_d  = ent_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_REST_MASS:    mass_d = pwdata[16:0];
        REG_ENTRIES_USED: ent_d  = pwdata[8:0];
        default:          mass_d = mass_q;
      endcase
    end
  end

  assign n_cnt   = ({23'd0, ent_q} > DEPTH32) ? NW'(TABLE_DEPTH) : NW'(ent_q);
  assign mid_sum = {1'b0, lo_q} + {1'b0, up_q};
  assign lo_m1   = lo_q - NW'(1);
  assign sq      = prod;
  assign frac_new = {frac_q[30:0], sq[63]};
  assign acc     = ph_q + {32'd0, prod[63:32]};
  assign mag28   = acc >> 4;
  assign num33   = {lg_q[31], lg_q} - {rd_grid_q[31], rd_grid_q};
  assign den33   = {g1_q[31], g1_q} - {rd_grid_q[31], rd_grid_q};

  assign wr_en   = in_fire && (item_i.operation == OP_WRITE) &&
                   ({24'd0, item_i.entry_index} < DEPTH32);
  assign wr_addr = IDXW'(item_i.entry_index);

  always_comb begin
    case (state_q)
      S_SQ_MUL: begin
        mul_a = mq_q;
        mul_b = mq_q;
      end
      S_MQ_HI: begin
        mul_a = mqa_q[63:32];
        mul_b = mqc_q;
      end
      S_MQ_LO: begin
        mul_a = mqa_q[31:0];
        mul_b = mqc_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    dph_d      = dph_q;
    mph_d      = mph_q;
    e_d        = e_q;
    norm_d     = norm_q;
    lz_d       = lz_q;
    mq_d       = mq_q;
    frac_d     = frac_q;
    cnt_d      = cnt_q;
    mqa_d      = mqa_q;
    mqc_d      = mqc_q;
    ph_d       = ph_q;
    lg_d       = lg_q;
    lo_d       = lo_q;
    up_d       = up_q;
    mid_d      = mid_q;
    g1_d       = g1_q;
    v1_d       = v1_q;
    v0_d       = v0_q;
    val_d      = val_q;
    outc_d     = outc_q;
    fin_res_d  = fin_res_q;
    fin_sat_d  = fin_sat_q;
    fin_outc_d = fin_outc_q;
    rd_addr    = '0;
    div_req    = '{start: 1'b0, dividend: e_q, shamt: 6'd0, divisor: e_q};
    item_i.ready = 1'b0;
    out_valid_d  = out_valid_q & ~result_o.ready;
    out_res_d    = out_res_q;
    out_sat_d    = out_sat_q;
    out_outc_d   = out_outc_q;

    case (state_q)
      S_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid && item_i.operation == OP_QUERY) begin
          e_d = item_i.energy_gev;
          if (mass_q == 17'd0 || item_i.energy_gev == 64'd0 ||
              item_i.energy_gev > {23'd0, mass_q, 24'd0}) begin
            fin_res_d  = '0;
            fin_sat_d  = 1'b0;
            fin_outc_d = OUTC_REJECT;
            state_d    = S_OUT;
          end else begin
            div_req = '{start: 1'b1, dividend: item_i.energy_gev, shamt: 6'd36,
                        divisor: {47'd0, mass_q}};
            dph_d   = DP_X;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          case (dph_q)
            DP_X: begin
              norm_d  = div_rsp.quot;
              lz_d    = '0;
              state_d = S_NORM;
            end
            DP_FRAC: begin
              mqa_d   = (v1_q >= v0_q) ? (v1_q - v0_q) : (v0_q - v1_q);
              mqc_d   = div_rsp.quot[31:0];
              mph_d   = MP_INTERP;
              state_d = S_MQ_HI;
            end
            DP_RES: begin
              fin_res_d  = div_rsp.quot;
              fin_sat_d  = div_rsp.ovf;
              fin_outc_d = outc_q;
              state_d    = S_OUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_NORM: begin
        if (norm_q[63]) begin
          mq_d    = norm_q[63:32];
          frac_d  = '0;
          cnt_d   = 6'd32;
          state_d = S_SQ_MUL;
        end else begin
          norm_d = {norm_q[62:0], 1'b0};
          lz_d   = lz_q + 7'd1;
        end
      end
      S_SQ_MUL: state_d = S_SQ_UPD;
      S_SQ_UPD: begin
        mq_d   = sq[63] ? sq[63:32] : sq[62:31];
        frac_d = frac_new;
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          mqa_d   = {25'd0, lz_q - 7'd3, 32'd0} - {32'd0, frac_new};
          mqc_d   = LOG10_2_Q32;
          mph_d   = MP_LOG;
          state_d = S_MQ_HI;
        end else begin
          state_d = S_SQ_MUL;
        end
      end
      S_MQ_HI: state_d = S_MQ_LO;
      S_MQ_LO: begin
        ph_d    = prod;
        state_d = S_MQ_SUM;
      end
      S_MQ_SUM: begin
        case (mph_q)
          MP_LOG: begin
            if (mag28 > MAG_LIMIT) begin
              fin_res_d  = '0;
              fin_sat_d  = 1'b0;
              fin_outc_d = OUTC_REJECT;
              state_d    = S_OUT;
            end else begin
              lg_d    = 32'd0 - mag28[31:0];
              lo_d    = '0;
              up_d    = n_cnt;
              state_d = S_SRCH;
            end
          end
          MP_INTERP: begin
            val_d   = (v1_q >= v0_q) ? (v0_q + acc) : (v0_q - acc);
            outc_d  = OUTC_INTERP;
            state_d = S_VAL;
          end
          MP_WEIGHT: begin
            div_req = '{start: 1'b1, dividend: acc, shamt: 6'd16, divisor: e_q};
            dph_d   = DP_RES;
            state_d = S_DIV;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SRCH: begin
        if (lo_q < up_q) begin
          mid_d   = mid_sum[NW:1];
          rd_addr = mid_sum[IDXW:1];
          state_d = S_SRCH_CMP;
        end else if (lo_q >= n_cnt) begin
          fin_res_d  = '0;
          fin_sat_d  = 1'b0;
          fin_outc_d = OUTC_REJECT;
          state_d    = S_OUT;
        end else begin
          rd_addr = lo_q[IDXW-1:0];
          state_d = S_CHK1;
        end
      end
      S_SRCH_CMP: begin
        if (rd_grid_q < lg_q) lo_d = mid_q + NW'(1);
        else up_d = mid_q;
        state_d = S_SRCH;
      end
      S_CHK1: begin
        g1_d = rd_grid_q;
        v1_d = rd_val_q;
        if (lo_q != '0 && rd_grid_q != lg_q) begin
          rd_addr = lo_m1[IDXW-1:0];
          state_d = S_CHK0;
        end else begin
          val_d   = rd_val_q;
          outc_d  = OUTC_EXACT;
          state_d = S_VAL;
        end
      end
      S_CHK0: begin
        if (rd_grid_q < lg_q && lg_q < g1_q) begin
          v0_d    = rd_val_q;
          div_req = '{start: 1'b1, dividend: {31'd0, num33}, shamt: 6'd32,
                      divisor: {31'd0, den33}};
          dph_d   = DP_FRAC;
          state_d = S_DIV;
        end else begin
          val_d   = v1_q;
          outc_d  = OUTC_EXACT;
          state_d = S_VAL;
        end
      end
      S_VAL: begin
        if (val_q == 64'd0) begin
          fin_res_d  = '0;
          fin_sat_d  = 1'b0;
          fin_outc_d = OUTC_REJECT;
          state_d    = S_OUT;
        end else begin
          mqa_d   = val_q;
          mqc_d   = INV_LN10_Q32;
          mph_d   = MP_WEIGHT;
          state_d = S_MQ_HI;
        end
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = fin_res_q;
          out_sat_d   = fin_sat_q;
          out_outc_d  = fin_outc_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dph_q       <= DP_X;
      mph_q       <= MP_LOG;
      mass_q      <= RST_REST_MASS;
      ent_q       <= RST_ENTRIES_USED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dph_q       <= dph_d;
      mph_q       <= mph_d;
      mass_q      <= mass_d;
      ent_q       <= ent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q        <= e_d;
    norm_q     <= norm_d;
    lz_q       <= lz_d;
    mq_q       <= mq_d;
    frac_q     <= frac_d;
    cnt_q      <= cnt_d;
    mqa_q      <= mqa_d;
    mqc_q      <= mqc_d;
    ph_q       <= ph_d;
    lg_q       <= lg_d;
    lo_q       <= lo_d;
    up_q       <= up_d;
    mid_q      <= mid_d;
    g1_q       <= g1_d;
    v1_q       <= v1_d;
    v0_q       <= v0_d;
    val_q      <= val_d;
    outc_q     <= outc_d;
    fin_res_q  <= fin_res_d;
    fin_sat_q  <= fin_sat_d;
    fin_outc_q <= fin_outc_d;
    out_res_q  <= out_res_d;
    out_sat_q  <= out_sat_d;
    out_outc_q <= out_outc_d;
  end

  // table storage, one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= item_i.grid_log10x;
      val_mem[wr_addr]  <= item_i.entry_value;
    end
    rd_grid_q <= grid_mem[rd_addr];
    rd_val_q  <= val_mem[rd_addr];
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.particles_per_energy = out_res_q;
  assign result_o.saturated            = out_sat_q;
  assign result_o.outcome              = out_outc_q;

`ifndef SYNTH
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && item_i.operation == OP_QUERY |=> !item_i.ready)
    else $error("query item did not make the block busy");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.outcome == OUTC_REJECT |->
      result_o.particles_per_energy == 64'd0 && !result_o.saturated)
    else $error("rejected item carries a nonzero result");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

[rtl/lgsi_divider.sv]
// bit-serial restoring divider computing floor(a * 2^k / d) with saturation
module lgsi_divider
  import lgsi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [63:0] a_q, a_d;
  logic [63:0] r_q, r_d;
  logic [63:0] q_q, q_d;
  logic [63:0] d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        o_q, o_d;
  logic [63:0] r_sh;
  logic        qb;

  always_comb begin
    a_d    = a_q;
    r_d    = r_q;
    q_d    = q_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    o_d    = o_q;
    done_d = 1'b0;
    r_sh   = {r_q[62:0], a_q[63]};
    qb     = r_q[63] | (r_sh >= d_q);
    if (req_i.start) begin
      a_d    = req_i.dividend;
      d_d    = req_i.divisor;
      r_d    = '0;
      q_d    = '0;
      o_d    = 1'b0;
      cnt_d  = 7'd64 + 7'(req_i.shamt);
      busy_d = 1'b1;
    end else if (busy_q) begin
      a_d   = {a_q[62:0], 1'b0};
      r_d   = qb ? (r_sh - d_q) : r_sh;
      o_d   = o_q | q_q[63];
      q_d   = {q_q[62:0], qb};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
    q_q <= q_d;
    d_q <= d_d;
    o_q <= o_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = o_q;
  assign rsp_o.quot = o_q ? '1 : q_q;

endmodule

[rtl/lgsi_mul.sv]
// shared 32x32 multiplier with registered product
module lgsi_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[tb/sv/log_grid_spectrum_interpolator_unit_tb.sv]
// testbench of the log-grid spectrum interpolator: table loads, queries and register settings
`timescale 1ns / 1ps

module log_grid_spectrum_interpolator_unit_tb
  import lgsi_pkg::*;
;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned WAIT_LIMIT = 20000;
  localparam int unsigned QUERY_WAIT = 450;
  localparam int unsigned HOLD_LEN   = 3000;
  localparam logic [2:0]  ADDR_MASS    = 3'(4 * REG_REST_MASS);
  localparam logic [2:0]  ADDR_ENTRIES = 3'(4 * REG_ENTRIES_USED);

  typedef struct {
    logic               op;
    logic [7:0]         idx;
    logic signed [31:0] grid;
    logic [63:0]        value;
    logic [63:0]        energy;
  } lgsi_item_t;

  typedef struct {
    logic [63:0] ppe;
    logic        sat;
    logic [1:0]  outc;
  } spectrum_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lgsi_item_if   item_bus ();
  lgsi_result_if res_bus ();

  log_grid_spectrum_interpolator_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [31:0] grid_tbl [DEPTH];
  logic [63:0]        value_tbl[DEPTH];
  logic [16:0]        cfg_mass;
  logic [8:0]         cfg_entries;
  spectrum_t          spectrum_q[$];

  int  errors;
  int  mismatches;
  int  idle_cycles;
  int  hold_cnt;
  bit  hold_start;
  bit  quiet;
  int  n_queries;
  int  n_writes;
  int  n_interp;
  int  n_exact;
  int  n_sat;
  int  n_reject;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [63:0] div_floor_shift(input logic [63:0] a, input int k,
                                                  input logic [63:0] d, output logic ovf);
    logic [63:0] q;
    logic [63:0] r;
    logic        top;
    logic        nb;
    logic        qb;
    q   = '0;
    r   = '0;
    ovf = 1'b0;
    for (int i = 0; i < 64 + k; i++) begin
      nb  = (i < 64) ? a[63 - i] : 1'b0;
      top = r[63];
      qb  = 1'b0;
      r   = {r[62:0], nb};
      if (top || r >= d) begin
        r  = r - d;
        qb = 1'b1;
      end
      if (q[63]) ovf = 1'b1;
      q = {q[62:0], qb};
    end
    if (ovf) q = '1;
    return q;
  endfunction

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [31:0] c);
    return (a >> 32) * 64'(c) + ((64'(a[31:0]) * 64'(c)) >> 32);
  endfunction

  function automatic spectrum_t predict_spectrum(input logic [63:0] e);
    spectrum_t   r;
    logic [63:0] m;
    logic [63:0] xq;
    logic [63:0] mq;
    logic [63:0] sq;
    logic [63:0] frac;
    logic [63:0] nmag;
    logic [63:0] mag28;
    logic [63:0] val;
    logic [63:0] f;
    logic [63:0] v0;
    logic [63:0] v1;
    logic        ovf;
    longint      lg;
    longint      g0;
    longint      g1;
    int          p;
    int          n;
    int          lo;
    int          hi;
    int          mid;
    r.ppe  = '0;
    r.sat  = 1'b0;
    r.outc = OUTC_REJECT;
    m = 64'(cfg_mass);
    if (m == 0 || e == 0 || e > (m << 24)) return r;
    xq = div_floor_shift(e, 36, m, ovf);
    p  = 0;
    for (int i = 0; i < 64; i++) if (xq[i]) p = i;
    mq   = (p >= 31) ? (xq >> (p - 31)) : (xq << (31 - p));
    frac = '0;
    for (int i = 0; i < 32; i++) begin
      sq = mq * mq;
      if (sq[63]) begin
        mq   = sq >> 32;
        frac = {frac[62:0], 1'b1};
      end else begin
        mq   = sq >> 31;
        frac = frac << 1;
      end
    end
    nmag  = (64'(60 - ((p > 60) ? 60 : p)) << 32) - frac;
    mag28 = mul_q32(nmag, LOG10_2_Q32) >> 4;
    if (mag28 > (64'd8 << 28)) return r;
    lg = -longint'(mag28);
    n  = (cfg_entries > DEPTH) ? DEPTH : int'(cfg_entries);
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (longint'(grid_tbl[mid]) < lg) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n) return r;
    val    = value_tbl[lo];
    r.outc = OUTC_EXACT;
    if (lo != 0 && longint'(grid_tbl[lo]) != lg) begin
      g0 = longint'(grid_tbl[lo - 1]);
      g1 = longint'(grid_tbl[lo]);
      if (g0 < lg && lg < g1) begin
        v0 = value_tbl[lo - 1];
        v1 = value_tbl[lo];
        f  = div_floor_shift(64'(lg - g0), 32, 64'(g1 - g0), ovf);
        if (v1 >= v0) val = v0 + mul_q32(v1 - v0, f[31:0]);
        else val = v0 - mul_q32(v0 - v1, f[31:0]);
        r.outc = OUTC_INTERP;
      end
    end
    if (val == 0) begin
      r.outc = OUTC_REJECT;
      return r;
    end
    r.ppe = div_floor_shift(mul_q32(val, INV_LN10_Q32), 16, e, ovf);
    r.sat = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    mismatches++;
    errors++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
  endtask

  // result side: random ready, long hold-off on request
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_cnt   = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    spectrum_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (spectrum_q.size() == 0) begin
        errors++;
        $display("result item with nothing expected");
      end else begin
        want = spectrum_q.pop_front();
        if (res_bus.particles_per_energy !== want.ppe)
          report_mismatch("particles_per_energy", want.ppe, res_bus.particles_per_energy);
        if (res_bus.saturated !== want.sat)
          report_mismatch("saturated", 64'(want.sat), 64'(res_bus.saturated));
        if (res_bus.outcome !== want.outc)
          report_mismatch("outcome", 64'(want.outc), 64'(res_bus.outcome));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WAIT_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("log_grid_spectrum_interpolator_unit_tb failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input lgsi_item_t it);
    spectrum_t want;
    while (!quiet && $urandom_range(99) < 29) begin
      item_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid       <= 1'b1;
    item_bus.operation   <= it.op;
    item_bus.entry_index <= it.idx;
    item_bus.grid_log10x <= it.grid;
    item_bus.entry_value <= it.value;
    item_bus.energy_gev  <= it.energy;
    do @(posedge clk_i); while (!item_bus.ready);
    if (it.op == OP_WRITE) begin
      grid_tbl[it.idx]  = it.grid;
      value_tbl[it.idx] = it.value;
      n_writes++;
    end else begin
      want = predict_spectrum(it.energy);
      spectrum_q.insert(spectrum_q.size(), want);
      n_queries++;
      case (want.outc)
        OUTC_INTERP: n_interp++;
        OUTC_EXACT:  n_exact++;
        default:     n_reject++;
      endcase
      if (want.sat) n_sat++;
    end
    @(negedge clk_i);
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic signed [31:0] g,
                             input logic [63:0] v);
    lgsi_item_t it;
    it.op     = OP_WRITE;
    it.idx    = idx;
    it.grid   = g;
    it.value  = v;
    it.energy = {$urandom, $urandom};
    send_item(it);
  endtask

  task automatic query(input logic [63:0] e);
    lgsi_item_t it;
    it.op     = OP_QUERY;
    it.idx    = 8'($urandom);
    it.grid   = $urandom;
    it.value  = {$urandom, $urandom};
    it.energy = e;
    send_item(it);
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    while (spectrum_q.size() != 0) @(negedge clk_i);
    repeat (QUERY_WAIT) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic [2:0] addr, input logic [31:0] data, input logic wr,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    apb_access(addr, '0, 1'b0, got);
    if (got !== want) report_mismatch("register readback", 64'(want), 64'(got));
  endtask

  task automatic set_config(input logic [16:0] mass, input logic [8:0] entries);
    logic [31:0] unused;
    drain();
    apb_access(ADDR_MASS, 32'(mass), 1'b1, unused);
    apb_access(ADDR_ENTRIES, 32'(entries), 1'b1, unused);
    cfg_mass    = mass;
    cfg_entries = entries;
    check_reg(ADDR_MASS, 32'(mass));
    check_reg(ADDR_ENTRIES, 32'(entries));
  endtask

  // energy with x between 1 and about 2^-30 of the mass
  function automatic logic [63:0] energy_below_mass();
    logic [63:0] top;
    logic [63:0] e;
    top = 64'(cfg_mass) << 24;
    e   = top >> $urandom_range(30);
    e   = e - (e >> $urandom_range(1, 8)) * ($urandom_range(3) == 0);
    return (e == 0) ? 64'd1 : e;
  endfunction

  function automatic logic [63:0] random_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(1000));
      default: return {$urandom, $urandom} >> $urandom_range(40);
    endcase
  endfunction

  task automatic load_sorted_table();
    longint g;
    g = -longint'(64'h8000_0000) + $urandom_range(1 << 20);
    for (int i = 0; i < DEPTH; i++) begin
      write_entry(8'(i), 32'(g), random_value());
      if ($urandom_range(15) != 0) g = g + $urandom_range(16842752);
      if (g > 0) g = 0;
    end
  endtask

  task automatic test_reset_values();
    check_reg(ADDR_MASS, 32'(RST_REST_MASS));
    check_reg(ADDR_ENTRIES, 32'(RST_ENTRIES_USED));
  endtask

  task automatic test_table_load();
    for (int i = 0; i < DEPTH; i++)
      write_entry(8'(i), (i == DEPTH - 1) ? 32'sd0 : 32'(-2147483648 + i * 8421504),
                  (i == 3) ? 64'd0 : (i == 7) ? '1 : {$urandom, $urandom});
  endtask

  task automatic test_directed();
    set_config(17'd100, 9'd256);
    query(64'd0);
    query((64'd100 << 24) + 1);
    query('1);
    query(64'd100 << 24);
    query(64'd1);
    query(64'd100 << 12);
    query(64'd100 << 20);
    // zero value around entry 3
    query((64'd100 << 24) >> 26);
    write_entry(8'd0, -32'sd1073741824, 64'h1234_5678_9abc);
    query((64'd100 << 24) >> 24);
    write_entry(8'd0, 32'h8000_0000, 64'h1234_5678_9abc);
    // unsorted neighbours
    write_entry(8'd200, 32'sd0, 64'h100_0000_0000);
    query((64'd100 << 24) >> 3);
    set_config(17'd1, 9'd256);
    query(64'd1);
    query(64'd1 << 24);
    set_config(17'd100000, 9'd2);
    query(64'd100000 << 24);
    query(64'd100000);
    set_config(17'h1ffff, 9'd0);
    query(64'h1ffff << 24);
    set_config(17'd0, 9'd300);
    query(64'd5);
    set_config(17'd100, 9'h1ff);
    query(64'd100 << 24);
    query((64'd100 << 24) >> 13);
  endtask

  task automatic test_random(input int count);
    logic [16:0] masses[5];
    logic [8:0]  sizes[6];
    int          idx;
    longint      lo_g;
    longint      hi_g;
    masses = '{17'd1, 17'd100000, 17'd100, 17'h1ffff, 17'd37};
    sizes  = '{9'd256, 9'd2, 9'd179, 9'd511, 9'd1, 9'd64};
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0)
        set_config((n % 300 == 150) ? 17'($urandom_range(1, 100000)) : masses[(n / 150) % 5],
                   sizes[(n / 150) % 6]);
      if (n % 350 == 200) load_sorted_table();
      quiet = (n >= 400 && n < 550);
      case ($urandom_range(19))
        0: query({$urandom, $urandom});
        1: query({$urandom, $urandom} >> $urandom_range(63));
        2: write_entry(8'($urandom), $urandom, random_value());
        3, 4: begin
          idx  = $urandom_range(1, DEPTH - 2);
          lo_g = longint'(grid_tbl[idx - 1]);
          hi_g = longint'(grid_tbl[idx + 1]);
          if (hi_g >= lo_g)
            write_entry(8'(idx), 32'(lo_g + longint'($urandom) % (hi_g - lo_g + 1)),
                        random_value());
          else
            write_entry(8'(idx), grid_tbl[idx], random_value());
        end
        default: query(energy_below_mass());
      endcase
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_start = 1'b1;
    for (int i = 0; i < 8; i++) query(energy_below_mass());
    drain();
    for (int i = 0; i < 4; i++) query(energy_below_mass());
  endtask

  initial begin
    errors      = 0;
    mismatches  = 0;
    idle_cycles = 0;
    hold_cnt    = 0;
    hold_start  = 1'b0;
    quiet       = 1'b0;
    n_queries   = 0;
    n_writes    = 0;
    n_interp    = 0;
    n_exact     = 0;
    n_sat       = 0;
    n_reject    = 0;
    cfg_mass    = RST_REST_MASS;
    cfg_entries = RST_ENTRIES_USED;
    for (int i = 0; i < DEPTH; i++) begin
      grid_tbl[i]  = '0;
      value_tbl[i] = '0;
    end
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    item_bus.valid       = 1'b0;
    item_bus.operation   = OP_WRITE;
    item_bus.entry_index = '0;
    item_bus.grid_log10x = '0;
    item_bus.entry_value = '0;
    item_bus.energy_gev  = '0;
    res_bus.ready        = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_table_load();
    test_directed();
    test_random(500);
    test_backpressure();
    drain();

    $display("%0d queries and %0d table writes: %0d interpolated, %0d grid hits, %0d zero",
             n_queries, n_writes, n_interp, n_exact, n_reject);
    $display("%0d saturated results, several mass and table-size settings", n_sat);
    if (errors == 0) begin
      $display("log_grid_spectrum_interpolator_unit_tb passed");
    end else begin
      $display("%0d errors", errors);
      $display("log_grid_spectrum_interpolator_unit_tb failed");
    end
    $finish;
  end

endmodule
